### design/sha256_pkg.sv
package sha256_pkg;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### design/sha256_byte_stream_hasher_top.sv
// Each message byte is taken only while the block is idle (in_ready high);
// every 64th byte starts a compression of 64 rounds through the single round
// unit plus one chaining add. Closing a message pads one byte per cycle, held
// during any compression, with a pause before the length; if the length does
// not fit, a second compression comes first. A final compression follows, and
// the eight digest words go out one per cycle while out_ready is high.
// Synchronous reset loads the initial hash values and clears length and fill.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  state_t      state;
  state_t      resume;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic [2:0]  word_idx;
  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [31:0] w_win [16];

  logic        in_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        wrap;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] ch;
  logic [31:0] maj;

  assign in_ready    = (state == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = (state == ST_OUT);
  assign digest_word = chain[word_idx];
  assign word_number = word_idx;
  assign final_word  = (word_idx == WORD_LAST);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = '0;
    unique case (state)
      ST_IDLE: begin
        wr_en   = in_acc && byte_present;
        wr_byte = msg_byte;
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_byte = PAD_MARK;
      end
      ST_ZERO: begin
        wr_en   = (fill != LEN_START);
        wr_byte = '0;
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = bit_length[{~fill[2:0], 3'b000} +: 8];
      end
      default: begin
        wr_en   = 1'b0;
        wr_byte = '0;
      end
    endcase
  end

  assign wrap = wr_en && (fill == FILL_LAST);

  assign ch    = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1    = wv[7] + big_sigma1(wv[4]) + ch + ROUND_K[round] + w_win[0];
  assign t2    = big_sigma0(wv[0]) + maj;
  assign w_new = small_sigma1(w_win[14]) + w_win[9] + small_sigma0(w_win[1]) + w_win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      resume     <= ST_IDLE;
      fill       <= '0;
      bit_length <= '0;
      round      <= '0;
      word_idx   <= '0;
      chain      <= HASH_INIT;
    end else begin
      if (wr_en) begin
        w_win[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
        fill <= fill + 6'd1;
      end
      if (wrap) begin
        wv    <= chain;
        round <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (byte_present) begin
              bit_length <= bit_length + 64'd8;
            end
            if (wrap) begin
              state  <= ST_ROUND;
              resume <= end_of_message ? ST_MARK : ST_IDLE;
            end else if (end_of_message) begin
              state <= ST_MARK;
            end
          end
        end
        ST_MARK: begin
          state  <= wrap ? ST_ROUND : ST_ZERO;
          resume <= ST_ZERO;
        end
        ST_ZERO: begin
          if (fill == LEN_START) begin
            state <= ST_LEN;
          end else if (wrap) begin
            state  <= ST_ROUND;
            resume <= ST_ZERO;
          end
        end
        ST_LEN: begin
          if (wrap) begin
            state  <= ST_ROUND;
            resume <= ST_OUT;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w_win[i] <= w_win[i + 1];
          end
          w_win[15] <= w_new;
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == ROUND_LAST) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + wv[i];
          end
          word_idx <= '0;
          state    <= resume;
        end
        ST_OUT: begin
          if (out_ready) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == WORD_LAST) begin
              chain      <= HASH_INIT;
              bit_length <= '0;
              fill       <= '0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sha256_chk.sv
module sha256_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_number,
  input logic        final_word
);

  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a digest is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_number))
    else $error("stalled digest word changed");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_word |=>
      out_valid && (word_number == 3'($past(word_number) + 3'd1)))
    else $error("digest words out of order");

  a_final_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (final_word == (word_number == 3'd7)))
    else $error("final word flag mismatch");

endmodule

bind sha256_byte_stream_hasher_top sha256_chk u_sha256_chk (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 396;

  localparam bit [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    bit [7:0] data;
    bit       present;
    bit       last;
    bit       drain_first;
  } byte_item_t;

  typedef struct {
    bit [31:0] digest;
    bit [2:0]  index;
    bit        final_flag;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  byte_item_t   pending_items[$];
  digest_word_t expected_words[$];

  bit [31:0] chain_state [8];
  bit [7:0]  block_buf [64];
  int unsigned block_fill;
  bit [63:0] message_bits;

  int unsigned error_count = 0;
  int unsigned words_accepted = 0;
  int unsigned words_checked = 0;
  int unsigned messages_hashed = 0;
  int unsigned blocks_compressed = 0;
  int unsigned cycle_count = 0;

  sha256_byte_stream_hasher_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .msg_byte(msg_byte),
    .byte_present(byte_present),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digest_word(digest_word),
    .word_number(word_number),
    .final_word(final_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles.", cycle_count);
    $display("** sha256_byte_stream_hasher_top: FAILED **");
    $finish;
  end

  function automatic bit [31:0] ror32(input bit [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_state[i] = SHA_IV[i];
    block_fill = 0;
    message_bits = '0;
  endtask

  task automatic compress_block();
    bit [31:0] w [64];
    bit [31:0] v [8];
    bit [31:0] t1;
    bit [31:0] t2;
    bit [31:0] g0;
    bit [31:0] g1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      g0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      g1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + g0 + w[i-7] + g1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_state[i] += v[i];
    blocks_compressed++;
  endtask

  task automatic absorb_item(input byte_item_t it);
    digest_word_t dw;
    bit [63:0] bits;
    if (it.present) begin
      block_buf[block_fill] = it.data;
      block_fill++;
      message_bits += 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (it.last) begin
      bits = message_bits;
      block_buf[block_fill] = 8'h80;
      for (int i = block_fill + 1; i < 64; i++) block_buf[i] = 8'h00;
      if (block_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_buf[56+i] = bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.digest = chain_state[i];
        dw.index = i[2:0];
        dw.final_flag = (i == 7);
        expected_words.insert(expected_words.size(), dw);
      end
      messages_hashed++;
      restart_hash();
    end
  endtask

  function automatic int unsigned pick_delay(input bit busy_stretch);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (busy_stretch || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_item(input bit [7:0] data, input bit present, input bit last,
                            input bit drain_first);
    byte_item_t it;
    it.data = data;
    it.present = present;
    it.last = last;
    it.drain_first = drain_first;
    pending_items.insert(pending_items.size(), it);
  endtask

  byte_item_t  cur_item;
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk) begin : driver
    bit next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        absorb_item(cur_item);
        words_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain_first || expected_words.size() == 0)) begin
          cur_item = pending_items.pop_front();
          msg_byte <= cur_item.data;
          byte_present <= cur_item.present;
          end_of_message <= cur_item.last;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = pick_delay(send_burst);
        end
      end
      in_valid <= next_valid;
    end
  end

  int unsigned stall_left = 0;
  bit          recv_burst = 1'b0;

  always @(posedge clk) begin : monitor
    digest_word_t dw;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected digest word %h (word_number %0d)", digest_word, word_number);
          error_count++;
        end else begin
          dw = expected_words.pop_front();
          words_checked++;
          if (digest_word !== dw.digest) begin
            $error("digest_word: expected %h, actual %h", dw.digest, digest_word);
            error_count++;
          end
          if (word_number !== dw.index) begin
            $error("word_number: expected %0d, actual %0d", dw.index, word_number);
            error_count++;
          end
          if (final_word !== dw.final_flag) begin
            $error("final_word: expected %0d, actual %0d", dw.final_flag, final_word);
            error_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        stall_left = pick_delay(recv_burst);
      end
    end
  end

  initial begin : stimulus
    int unsigned random_count;
    int unsigned msg_len;
    int unsigned msg_index;
    bit          close_alone;
    int unsigned edge_lengths [12];
    edge_lengths = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    restart_hash();

    queue_item(8'h5a, 1'b0, 1'b1, 1'b0);
    queue_item(8'hff, 1'b0, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);
    queue_item(8'hff, 1'b1, 1'b1, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0, 1'b0);
    queue_item(8'h80, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    queue_item(8'h55, 1'b1, 1'b0, 1'b0);
    queue_item(8'h3c, 1'b0, 1'b0, 1'b0);
    queue_item(8'haa, 1'b1, 1'b1, 1'b0);
    queue_item(8'hff, 1'b0, 1'b1, 1'b0);

    random_count = 0;
    msg_index = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) msg_len = edge_lengths[$urandom_range(0, 11)];
      else msg_len = $urandom_range(0, 12);
      close_alone = (msg_len == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_item(8'($urandom), 1'b0, 1'b0, 1'b0);
          random_count++;
        end
        queue_item(pick_byte(), 1'b1, (i == msg_len - 1) && !close_alone,
                   (i == 0) && (msg_index % 12 == 0));
      end
      if (close_alone) queue_item(8'($urandom), 1'b0, 1'b1, (msg_len == 0) && (msg_index % 12 == 0));
      random_count += msg_len + close_alone;
      msg_index++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d input words (%0d blocks compressed).",
             messages_hashed, words_accepted, blocks_compressed);
    $display("Checked %0d digest words, %0d mismatches.", words_checked, error_count);
    if (error_count == 0) begin
      $display("** sha256_byte_stream_hasher_top: PASSED **");
    end else begin
      $display("** sha256_byte_stream_hasher_top: FAILED **");
    end
    $finish;
  end

endmodule
